// File: hw/rtl/br1bpd_pkg.sv
package br1bpd_pkg;

    // field and state widths
    localparam int LINE_W     = 14;
    localparam int ROW_W      = 16;
    localparam int PLANE_W    = 3;
    localparam int PCNT_W     = 4;
    localparam int RUN_W      = 8;
    localparam int WCNT_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // largest word count of one repeat run, minus one
    localparam logic [WCNT_W-1:0] WCNT_LAST = 6'd63;

    // compression modes
    localparam logic MODE_RAW = 1'b0;

    // register reset values
    localparam logic              MODE_RESET        = 1'b1;
    localparam logic [LINE_W-1:0] LINE_BYTES_RESET  = 14'd40;
    localparam logic [PCNT_W-1:0] PLANE_COUNT_RESET = 4'd5;
    localparam logic [ROW_W-1:0]  ROW_COUNT_RESET   = 16'd256;

    // decode phase of the run-length parser
    typedef enum logic [1:0] {
        PH_CONTROL = 2'd0,
        PH_LITERAL = 2'd1,
        PH_REPEAT  = 2'd2,
        PH_DISCARD = 2'd3
    } phase_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE        = 2'd0,
        CFG_LINE_BYTES  = 2'd1,
        CFG_PLANE_COUNT = 2'd2,
        CFG_ROW_COUNT   = 2'd3
    } cfg_index_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REPEAT
    } ctrl_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic step;
        logic rep_push;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic slot_free;
        logic go_repeat;
        logic rep_last;
    } dp_sts_t;

endpackage

// File: hw/rtl/byterun1_bitplane_decoder.sv
// ByteRun1 bitplane body decoder. Bytes of the image body enter one per request on the
// input channel; 16-bit bitplane words, each tagged with plane, row and end flags, leave
// on the output channel. Every byte is first accepted, then decoded, and the input stays
// closed until its decode step is done. The value byte of a repeat run then keeps the
// input closed while the word packer takes the repeated byte once per cycle while the
// output register can take a word, up to 128 times (at most 64 words); the run is clipped
// early at a line end or at the word limit. There is a single packer and a one-word output
// register; any cycle in which the output register still holds an untaken word stalls the
// packer and the decode step. Configuration writes are always taken (cfg_ready is tied
// high) and must only be issued while idle.
module byterun1_bitplane_decoder (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           data_byte,
    input  logic                                 frame_start,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [15:0]                          out_word,
    output logic [br1bpd_pkg::PLANE_W-1:0]       plane_index,
    output logic [br1bpd_pkg::ROW_W-1:0]         row_index,
    output logic                                 line_end,
    output logic                                 image_end,
    output logic                                 overrun,
    output logic                                 last_of_input,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [br1bpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [br1bpd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    br1bpd_pkg::dp_cmd_t cmd;
    br1bpd_pkg::dp_sts_t sts;

    // configuration port never stalls
    assign cfg_ready = 1'b1;

    // sequencer
    br1bpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // decode, packing and output slot
    br1bpd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .data_byte     (data_byte),
        .frame_start   (frame_start),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .out_word      (out_word),
        .plane_index   (plane_index),
        .row_index     (row_index),
        .line_end      (line_end),
        .image_end     (image_end),
        .overrun       (overrun),
        .last_of_input (last_of_input)
    );

endmodule

// File: hw/rtl/br1bpd_datapath.sv
module br1bpd_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  br1bpd_pkg::dp_cmd_t                  cmd,
    output br1bpd_pkg::dp_sts_t                  sts,
    input  logic [7:0]                           data_byte,
    input  logic                                 frame_start,
    input  logic                                 cfg_we,
    input  logic [br1bpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [br1bpd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [15:0]                          out_word,
    output logic [br1bpd_pkg::PLANE_W-1:0]       plane_index,
    output logic [br1bpd_pkg::ROW_W-1:0]         row_index,
    output logic                                 line_end,
    output logic                                 image_end,
    output logic                                 overrun,
    output logic                                 last_of_input
);

    // configuration registers
    logic                              mode_reg;
    logic [br1bpd_pkg::LINE_W-1:0]     line_bytes_reg;
    logic [br1bpd_pkg::PCNT_W-1:0]     plane_count_reg;
    logic [br1bpd_pkg::ROW_W-1:0]      row_count_reg;

    // decode state
    logic [7:0]                        byte_reg;
    br1bpd_pkg::phase_t                phase_reg, phase_next;
    logic [br1bpd_pkg::RUN_W-1:0]      run_reg, run_next;
    logic [7:0]                        hold_reg, hold_next;
    logic                              hbv_reg, hbv_next;
    logic [br1bpd_pkg::LINE_W-1:0]     lcount_reg, lcount_next;
    logic [br1bpd_pkg::PLANE_W-1:0]    plane_reg, plane_next;
    logic [br1bpd_pkg::ROW_W-1:0]      row_reg, row_next;
    logic                              done_reg, done_next;
    logic [br1bpd_pkg::WCNT_W-1:0]     wcnt_reg, wcnt_next;

    // output slot
    logic                              out_valid_reg;
    logic [15:0]                       out_word_reg;
    logic [br1bpd_pkg::PLANE_W-1:0]    plane_index_reg;
    logic [br1bpd_pkg::ROW_W-1:0]      row_index_reg;
    logic                              line_end_reg;
    logic                              image_end_reg;
    logic                              overrun_reg;
    logic                              last_reg;

    // effective geometry
    logic [br1bpd_pkg::LINE_W-1:0]     eff_line;
    logic [br1bpd_pkg::PCNT_W-1:0]     eff_planes;
    logic [br1bpd_pkg::ROW_W-1:0]      eff_rows;

    // packer controls and results
    logic                              push_en;
    logic                              push_more;
    logic                              word_push;
    logic                              le;
    logic                              pwrap;
    logic                              rwrap;
    logic                              img_end_c;
    logic                              word_last;
    logic                              rep_last;
    logic [br1bpd_pkg::RUN_W-1:0]      run_dec;
    logic [br1bpd_pkg::LINE_W-1:0]     lcount_inc;
    logic [br1bpd_pkg::PLANE_W-1:0]    plane_inc;
    logic [br1bpd_pkg::ROW_W-1:0]      row_inc;
    logic                              decode_step;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= br1bpd_pkg::MODE_RESET;
            line_bytes_reg  <= br1bpd_pkg::LINE_BYTES_RESET;
            plane_count_reg <= br1bpd_pkg::PLANE_COUNT_RESET;
            row_count_reg   <= br1bpd_pkg::ROW_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (br1bpd_pkg::cfg_index_t'(cfg_index))
                br1bpd_pkg::CFG_MODE:        mode_reg        <= cfg_data[0];
                br1bpd_pkg::CFG_LINE_BYTES:  line_bytes_reg  <= cfg_data[br1bpd_pkg::LINE_W-1:0];
                br1bpd_pkg::CFG_PLANE_COUNT: plane_count_reg <= cfg_data[br1bpd_pkg::PCNT_W-1:0];
                br1bpd_pkg::CFG_ROW_COUNT:   row_count_reg   <= cfg_data[br1bpd_pkg::ROW_W-1:0];
            endcase
        end
    end

    // clamp odd, tiny and out-of-range geometry
    always_comb
    begin
        if (line_bytes_reg[br1bpd_pkg::LINE_W-1:1] == '0)
            eff_line = 14'd2;
        else
            eff_line = {line_bytes_reg[br1bpd_pkg::LINE_W-1:1], 1'b0};

        if (plane_count_reg == 4'd0)
            eff_planes = 4'd1;
        else if (plane_count_reg > 4'd8)
            eff_planes = 4'd8;
        else
            eff_planes = plane_count_reg;

        eff_rows = (row_count_reg == '0) ? 16'd1 : row_count_reg;
    end

    assign run_dec     = (run_reg != '0) ? run_reg - 8'd1 : run_reg;
    assign decode_step = cmd.step && !done_reg;

    // pick which byte reaches the packer this cycle
    always_comb
    begin
        push_en   = 1'b0;
        push_more = 1'b0;
        if (decode_step && mode_reg == br1bpd_pkg::MODE_RAW)
        begin
            push_en = 1'b1;
        end
        else if (decode_step && phase_reg == br1bpd_pkg::PH_LITERAL)
        begin
            push_en   = 1'b1;
            push_more = (run_dec != '0);
        end
        else if (cmd.rep_push)
        begin
            push_en   = 1'b1;
            push_more = (run_dec != '0);
        end
    end

    // word packer and line, plane, row tracking
    assign lcount_inc = lcount_reg + 14'd1;
    assign plane_inc  = plane_reg + 3'd1;
    assign row_inc    = row_reg + 16'd1;
    assign word_push  = push_en && hbv_reg;
    assign le         = word_push && (lcount_inc >= eff_line);
    assign pwrap      = ({1'b0, plane_inc} >= eff_planes) || (plane_inc == '0);
    assign rwrap      = (row_inc >= eff_rows) || (row_inc == '0);
    assign img_end_c  = le && pwrap && rwrap;

    // a repeat run ends on a line end, when bytes run out, or at the word limit
    assign word_last = cmd.rep_push
                     ? (le || run_dec <= 8'd1 || wcnt_reg == br1bpd_pkg::WCNT_LAST)
                     : 1'b1;
    assign rep_last  = (run_dec == '0)
                     || (word_push && (le || wcnt_reg == br1bpd_pkg::WCNT_LAST));

    // next decode state
    always_comb
    begin
        phase_next  = phase_reg;
        run_next    = run_reg;
        hold_next   = hold_reg;
        hbv_next    = hbv_reg;
        lcount_next = lcount_reg;
        plane_next  = plane_reg;
        row_next    = row_reg;
        done_next   = done_reg;
        wcnt_next   = wcnt_reg;

        // packer update
        if (push_en)
        begin
            if (!hbv_reg)
            begin
                hold_next   = byte_reg;
                hbv_next    = 1'b1;
                lcount_next = lcount_inc;
            end
            else
            begin
                hbv_next = 1'b0;
                if (le)
                begin
                    lcount_next = '0;
                    plane_next  = pwrap ? '0 : plane_inc;
                    if (pwrap)
                    begin
                        row_next = row_inc;
                        if (rwrap)
                            done_next = 1'b1;
                    end
                end
                else
                begin
                    lcount_next = lcount_inc;
                end
            end
        end

        // run-length parser
        if (decode_step && mode_reg != br1bpd_pkg::MODE_RAW)
        begin
            unique case (phase_reg)
                br1bpd_pkg::PH_CONTROL:
                begin
                    if (!byte_reg[7])
                    begin
                        run_next   = {1'b0, byte_reg[6:0]} + 8'd1;
                        phase_next = br1bpd_pkg::PH_LITERAL;
                    end
                    else if (byte_reg[6:0] != '0)
                    begin
                        run_next   = 8'd1 - byte_reg;
                        phase_next = br1bpd_pkg::PH_REPEAT;
                    end
                end
                br1bpd_pkg::PH_LITERAL:
                begin
                    run_next = run_dec;
                    if (le && run_dec != '0)
                        phase_next = br1bpd_pkg::PH_DISCARD;
                    else if (run_dec == '0)
                        phase_next = br1bpd_pkg::PH_CONTROL;
                end
                br1bpd_pkg::PH_REPEAT:
                begin
                    wcnt_next = '0;
                    if (run_reg == '0)
                        phase_next = br1bpd_pkg::PH_CONTROL;
                end
                br1bpd_pkg::PH_DISCARD:
                begin
                    run_next = run_dec;
                    if (run_dec == '0)
                        phase_next = br1bpd_pkg::PH_CONTROL;
                end
            endcase
        end

        // repeat run countdown
        if (cmd.rep_push)
        begin
            run_next = run_dec;
            if (word_push)
                wcnt_next = wcnt_reg + 6'd1;
            if (rep_last)
            begin
                run_next   = '0;
                phase_next = br1bpd_pkg::PH_CONTROL;
            end
        end

        // frame restart ahead of the new byte
        if (cmd.accept && frame_start)
        begin
            phase_next  = br1bpd_pkg::PH_CONTROL;
            run_next    = '0;
            hold_next   = '0;
            hbv_next    = 1'b0;
            lcount_next = '0;
            plane_next  = '0;
            row_next    = '0;
            done_next   = 1'b0;
        end
    end

    // decode state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= br1bpd_pkg::PH_CONTROL;
            run_reg    <= '0;
            hold_reg   <= '0;
            hbv_reg    <= 1'b0;
            lcount_reg <= '0;
            plane_reg  <= '0;
            row_reg    <= '0;
            done_reg   <= 1'b0;
            wcnt_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            run_reg    <= run_next;
            hold_reg   <= hold_next;
            hbv_reg    <= hbv_next;
            lcount_reg <= lcount_next;
            plane_reg  <= plane_next;
            row_reg    <= row_next;
            done_reg   <= done_next;
            wcnt_reg   <= wcnt_next;
        end
    end

    // input byte latch
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            byte_reg <= data_byte;
    end

    // output slot valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (word_push)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // output slot payload
    always_ff @(posedge clk)
    begin
        if (word_push)
        begin
            out_word_reg    <= {hold_reg, byte_reg};
            plane_index_reg <= plane_reg;
            row_index_reg   <= row_reg;
            line_end_reg    <= le;
            image_end_reg   <= img_end_c;
            overrun_reg     <= le && push_more;
            last_reg        <= word_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_word      = out_word_reg;
    assign plane_index   = plane_index_reg;
    assign row_index     = row_index_reg;
    assign line_end      = line_end_reg;
    assign image_end     = image_end_reg;
    assign overrun       = overrun_reg;
    assign last_of_input = last_reg;

    // status to the controller
    assign sts.slot_free = !out_valid_reg || out_ready;
    assign sts.go_repeat = (mode_reg != br1bpd_pkg::MODE_RAW) && !done_reg
                         && (phase_reg == br1bpd_pkg::PH_REPEAT) && (run_reg != '0);
    assign sts.rep_last  = rep_last;

    // a run in progress always has bytes left
    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != br1bpd_pkg::PH_CONTROL |-> run_reg != '0)
        else $error("run count empty outside control phase");

    // a finished image sits at the start of a row
    a_done_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (plane_reg == '0 && lcount_reg == '0 && !hbv_reg))
        else $error("image done with partial row state");

    // a word is only packed into a free output slot
    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        word_push && !out_ready |-> !out_valid_reg)
        else $error("word packed over a pending result");

    // no words once the image is complete
    a_no_word_done: assert property (@(posedge clk) disable iff (!rst_n)
        word_push |-> !done_reg)
        else $error("word packed after image end");

endmodule

// File: hw/rtl/br1bpd_ctrl.sv
module br1bpd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  br1bpd_pkg::dp_sts_t  sts,
    output br1bpd_pkg::dp_cmd_t  cmd
);

    br1bpd_pkg::ctrl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= br1bpd_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            br1bpd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = br1bpd_pkg::ST_EXEC;
                end
            end
            br1bpd_pkg::ST_EXEC:
            begin
                if (sts.slot_free)
                begin
                    cmd.step   = 1'b1;
                    state_next = sts.go_repeat ? br1bpd_pkg::ST_REPEAT : br1bpd_pkg::ST_IDLE;
                end
            end
            br1bpd_pkg::ST_REPEAT:
            begin
                if (sts.slot_free)
                begin
                    cmd.rep_push = 1'b1;
                    if (sts.rep_last)
                        state_next = br1bpd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = br1bpd_pkg::ST_IDLE;
            end
        endcase
    end

    // repeat expansion only runs while the datapath holds a live repeat run
    a_repeat_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == br1bpd_pkg::ST_REPEAT |-> sts.go_repeat)
        else $error("repeat state without a live repeat run");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int SETTLE_CYCLES = 300;
    localparam int STALL_LIMIT   = 5000;
    localparam int PHASE_ITEMS   = 40;
    localparam int RANDOM_PHASES = 6;
    localparam logic MODE_RLE    = ~br1bpd_pkg::MODE_RAW;

    // one body byte waiting to be sent
    typedef struct {
        logic [7:0] value;
        logic       restart;
        bit         hold;
    } body_req_t;

    // one decoded bitplane word with its tags
    typedef struct {
        logic [15:0]                    word;
        logic [br1bpd_pkg::PLANE_W-1:0] plane;
        logic [br1bpd_pkg::ROW_W-1:0]   row;
        logic                           le;
        logic                           ie;
        logic                           ovr;
        logic                           fin;
    } bp_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [7:0] data_byte = 8'd0;
    logic frame_start = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [15:0] out_word;
    logic [br1bpd_pkg::PLANE_W-1:0] plane_index;
    logic [br1bpd_pkg::ROW_W-1:0] row_index;
    logic line_end;
    logic image_end;
    logic overrun;
    logic last_of_input;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [br1bpd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [br1bpd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    byterun1_bitplane_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .frame_start   (frame_start),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_word      (out_word),
        .plane_index   (plane_index),
        .row_index     (row_index),
        .line_end      (line_end),
        .image_end     (image_end),
        .overrun       (overrun),
        .last_of_input (last_of_input),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    body_req_t pending_bytes[$];
    bp_word_t  exp_words[$];
    bp_word_t  word_batch[$];

    int  errors = 0;
    int  word_no = 0;
    int  quiet_cycles = 0;
    int  phase_count = 0;
    int  idle_in_pct = 23;
    int  idle_out_pct = 57;
    bit  in_taken = 1'b0;

    // shadow of the configuration registers
    logic                          mode_r;
    logic [br1bpd_pkg::LINE_W-1:0] line_r;
    logic [br1bpd_pkg::PCNT_W-1:0] planes_r;
    logic [br1bpd_pkg::ROW_W-1:0]  rows_r;

    // shadow of the decoder state
    br1bpd_pkg::phase_t             ph;
    logic [br1bpd_pkg::RUN_W-1:0]   run_left;
    logic [7:0]                     hold_b;
    bit                             hold_v;
    logic [br1bpd_pkg::LINE_W-1:0]  line_cnt;
    logic [br1bpd_pkg::PLANE_W-1:0] plane_pos;
    logic [br1bpd_pkg::ROW_W-1:0]   row_pos;
    bit                             img_done;

    function automatic void rewind_image();
        ph = br1bpd_pkg::PH_CONTROL;
        run_left = '0;
        hold_b = '0;
        hold_v = 1'b0;
        line_cnt = '0;
        plane_pos = '0;
        row_pos = '0;
        img_done = 1'b0;
    endfunction

    // pack one byte into the word builder, returns 1 when a plane row ended
    function automatic bit pack_byte(input logic [7:0] b, input bit more);
        bp_word_t w;
        bit       le;
        bit       ie;
        int       lim;
        int       pl;
        int       rw;
        if (img_done || word_batch.size() >= 64)
            return 1'b0;
        line_cnt = line_cnt + 1'b1;
        if (!hold_v)
        begin
            hold_b = b;
            hold_v = 1'b1;
            return 1'b0;
        end
        hold_v = 1'b0;
        w.word = {hold_b, b};
        w.plane = plane_pos;
        w.row = row_pos;
        lim = int'(line_r & 14'h3FFE);
        if (lim < 2)
            lim = 2;
        le = (line_cnt >= lim);
        ie = 1'b0;
        if (le)
        begin
            line_cnt = '0;
            plane_pos = plane_pos + 1'b1;
            pl = (planes_r == 0) ? 1 : ((planes_r > 8) ? 8 : int'(planes_r));
            if (plane_pos >= pl || plane_pos == 0)
            begin
                plane_pos = '0;
                row_pos = row_pos + 1'b1;
                rw = (rows_r == 0) ? 1 : int'(rows_r);
                if (row_pos >= rw || row_pos == 0)
                begin
                    ie = 1'b1;
                    img_done = 1'b1;
                end
            end
        end
        w.le = le;
        w.ie = ie;
        w.ovr = le && more;
        w.fin = 1'b0;
        word_batch = {word_batch, w};
        return le;
    endfunction

    // expected words for one accepted body byte
    function automatic void decode_byte(input logic [7:0] b, input logic restart);
        bp_word_t w;
        int       i;
        word_batch.delete();
        if (restart)
            rewind_image();
        if (!img_done)
        begin
            if (mode_r == br1bpd_pkg::MODE_RAW)
                void'(pack_byte(b, 1'b0));
            else
            begin
                case (ph)
                    br1bpd_pkg::PH_CONTROL:
                    begin
                        if (b < 8'd128)
                        begin
                            run_left = b + 8'd1;
                            ph = br1bpd_pkg::PH_LITERAL;
                        end
                        else if (b > 8'd128)
                        begin
                            run_left = 8'(9'd257 - {1'b0, b});
                            ph = br1bpd_pkg::PH_REPEAT;
                        end
                    end
                    br1bpd_pkg::PH_LITERAL:
                    begin
                        if (run_left != 0)
                            run_left = run_left - 1'b1;
                        if (pack_byte(b, run_left != 0) && run_left != 0)
                            ph = br1bpd_pkg::PH_DISCARD;
                        else if (run_left == 0)
                            ph = br1bpd_pkg::PH_CONTROL;
                    end
                    br1bpd_pkg::PH_REPEAT:
                    begin
                        for (i = 0; i < run_left; i++)
                        begin
                            if (img_done)
                                break;
                            if (pack_byte(b, (i + 1) < run_left))
                                break;
                        end
                        run_left = '0;
                        ph = br1bpd_pkg::PH_CONTROL;
                    end
                    default:
                    begin
                        if (run_left != 0)
                            run_left = run_left - 1'b1;
                        if (run_left == 0)
                            ph = br1bpd_pkg::PH_CONTROL;
                    end
                endcase
            end
        end
        if (word_batch.size() > 0)
        begin
            w = word_batch.pop_back();
            w.fin = 1'b1;
            word_batch = {word_batch, w};
        end
        exp_words = {exp_words, word_batch};
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] word %0d %s: got 0x%0h, expected 0x%0h",
                 $time, word_no, field, got, want);
        errors++;
    endtask

    // request driver, inputs change on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (pending_bytes.size() != 0
                && !(pending_bytes[0].hold && exp_words.size() != 0)
                && $urandom_range(0, 99) >= idle_in_pct)
            begin
                data_byte <= pending_bytes[0].value;
                frame_start <= pending_bytes[0].restart;
                in_valid <= 1'b1;
                void'(pending_bytes.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    // accepted requests feed the predictor
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            decode_byte(data_byte, frame_start);
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= idle_out_pct);
    end

    // output monitor
    always @(posedge clk)
    begin : monitor
        bp_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (exp_words.size() == 0)
                report_mismatch("unexpected word", 32'(out_word), 32'd0);
            else
            begin
                want = exp_words.pop_front();
                if (out_word !== want.word)
                    report_mismatch("out_word", 32'(out_word), 32'(want.word));
                if (plane_index !== want.plane)
                    report_mismatch("plane_index", 32'(plane_index), 32'(want.plane));
                if (row_index !== want.row)
                    report_mismatch("row_index", 32'(row_index), 32'(want.row));
                if (line_end !== want.le)
                    report_mismatch("line_end", 32'(line_end), 32'(want.le));
                if (image_end !== want.ie)
                    report_mismatch("image_end", 32'(image_end), 32'(want.ie));
                if (overrun !== want.ovr)
                    report_mismatch("overrun", 32'(overrun), 32'(want.ovr));
                if (last_of_input !== want.fin)
                    report_mismatch("last_of_input", 32'(last_of_input), 32'(want.fin));
            end
            word_no++;
        end
    end

    // no handshake on any channel for too long ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic add_req(input logic [7:0] value, input logic restart);
        body_req_t r;
        r.value = value;
        r.restart = restart;
        r.hold = (phase_count == 10);
        pending_bytes = {pending_bytes, r};
        phase_count++;
    endtask

    // one well-formed run with random content, or a stray byte
    task automatic add_packet(input bit raw);
        int         r;
        int         n;
        logic [7:0] ctl;
        bit         fs;
        fs = ($urandom_range(0, 5) == 0);
        r = $urandom_range(0, 99);
        if (raw)
            add_req(8'($urandom_range(0, 255)), fs);
        else if (r < 5)
            add_req(8'd128, fs);
        else if (r < 45)
        begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
            add_req(8'(n), fs);
            repeat (n + 1)
                add_req(8'($urandom_range(0, 255)), 1'b0);
        end
        else if (r < 88)
        begin
            ctl = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(129, 255))
                                               : 8'($urandom_range(240, 255));
            add_req(ctl, fs);
            add_req(8'($urandom_range(0, 255)), 1'b0);
        end
        else
            add_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // wait until the block is idle and nothing is outstanding
    task automatic drain();
        while (pending_bytes.size() != 0 || in_valid)
            @(posedge clk);
        while (exp_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input br1bpd_pkg::cfg_index_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            br1bpd_pkg::CFG_MODE:        mode_r = val[0];
            br1bpd_pkg::CFG_LINE_BYTES:  line_r = val[br1bpd_pkg::LINE_W-1:0];
            br1bpd_pkg::CFG_PLANE_COUNT: planes_r = val[br1bpd_pkg::PCNT_W-1:0];
            default:                     rows_r = val;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stimulus and end of run
    initial
    begin
        int m;
        int lb;
        int pc;
        int rc;
        mode_r = br1bpd_pkg::MODE_RESET;
        line_r = br1bpd_pkg::LINE_BYTES_RESET;
        planes_r = br1bpd_pkg::PLANE_COUNT_RESET;
        rows_r = br1bpd_pkg::ROW_COUNT_RESET;
        rewind_image();
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: extreme bytes, no-op, short repeat, repeat clipped at line end
        add_req(8'h01, 1'b1);
        add_req(8'hFF, 1'b0);
        add_req(8'h00, 1'b0);
        add_req(8'd128, 1'b0);
        add_req(8'hFF, 1'b0);
        add_req(8'h80, 1'b0);
        add_req(8'h81, 1'b0);
        add_req(8'h7F, 1'b0);
        drain();

        // literal run longer than the line, tail is dropped
        write_reg(br1bpd_pkg::CFG_LINE_BYTES, 16'd2);
        add_req(8'h03, 1'b1);
        add_req(8'h12, 1'b0);
        add_req(8'h34, 1'b0);
        add_req(8'h56, 1'b0);
        add_req(8'h78, 1'b0);
        drain();

        // line shortened to the count already reached
        write_reg(br1bpd_pkg::CFG_LINE_BYTES, 16'd40);
        add_req(8'hFF, 1'b0);
        add_req(8'h11, 1'b0);
        drain();
        write_reg(br1bpd_pkg::CFG_LINE_BYTES, 16'd2);
        add_req(8'hFE, 1'b0);
        add_req(8'h22, 1'b0);

        // mode flip in the middle of a literal run
        add_req(8'h03, 1'b0);
        add_req(8'hA5, 1'b0);
        drain();
        write_reg(br1bpd_pkg::CFG_MODE, 16'(br1bpd_pkg::MODE_RAW));
        add_req(8'h5A, 1'b0);
        add_req(8'hC3, 1'b0);
        drain();
        write_reg(br1bpd_pkg::CFG_MODE, 16'(MODE_RLE));
        add_req(8'h3C, 1'b0);
        drain();

        // tiny line, zero planes and rows: first word ends the image, rest ignored
        write_reg(br1bpd_pkg::CFG_LINE_BYTES, 16'd1);
        write_reg(br1bpd_pkg::CFG_PLANE_COUNT, 16'd0);
        write_reg(br1bpd_pkg::CFG_ROW_COUNT, 16'd0);
        add_req(8'hFF, 1'b1);
        add_req(8'h33, 1'b0);
        add_req(8'h00, 1'b0);
        add_req(8'hEE, 1'b0);
        drain();

        // random phases, each under its own settings
        for (int k = 0; k < RANDOM_PHASES; k++)
        begin
            if (k < 2)
            begin
                idle_in_pct = 23;
                idle_out_pct = 57;
            end
            else if (k < 4)
            begin
                idle_in_pct = 57;
                idle_out_pct = 23;
            end
            else
            begin
                idle_in_pct = 0;
                idle_out_pct = 0;
            end
            m = 1;
            case (k)
                0:
                begin
                    lb = 2 * $urandom_range(2, 12);
                    pc = 8;
                    rc = $urandom_range(1, 3);
                end
                1:
                begin
                    lb = $urandom_range(2, 12);
                    pc = 1;
                    rc = 65535;
                end
                2:
                begin
                    m = 0;
                    lb = $urandom_range(2, 20);
                    pc = $urandom_range(1, 8);
                    rc = $urandom_range(1, 2);
                end
                3:
                begin
                    lb = 2;
                    pc = 15;
                    rc = 1;
                end
                4:
                begin
                    lb = 8192;
                    pc = $urandom_range(1, 8);
                    rc = $urandom_range(1, 65535);
                end
                default:
                begin
                    lb = $urandom_range(0, 16);
                    pc = 0;
                    rc = 0;
                end
            endcase
            write_reg(br1bpd_pkg::CFG_MODE, 16'(m));
            write_reg(br1bpd_pkg::CFG_LINE_BYTES, 16'(lb));
            write_reg(br1bpd_pkg::CFG_PLANE_COUNT, 16'(pc));
            write_reg(br1bpd_pkg::CFG_ROW_COUNT, 16'(rc));
            phase_count = 0;
            while (phase_count < PHASE_ITEMS)
                add_packet(m == 0);
            drain();
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/br1bpd_pkg.sv
hw/rtl/br1bpd_datapath.sv
hw/rtl/br1bpd_ctrl.sv
hw/rtl/byterun1_bitplane_decoder.sv
verif/tb.sv
